// ===== rtl/pdfr_pkg.sv =====
`default_nettype none
package pdfr_pkg;

  localparam int THR_W      = 8;
  localparam int CODE_W     = 8;
  localparam int SHIFT_W    = 8;
  localparam int CFG_DATA_W = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int BITS_W     = 4;
  localparam int LOADS      = 3;

  localparam int DEF_BITS_PER_FRAME = 8;
  localparam int DEF_COUNTER_WIDTH  = 8;

  localparam logic [THR_W-1:0]  RST_SYNC_THRESHOLD = 8'd100;
  localparam logic [THR_W-1:0]  RST_ONE_THRESHOLD  = 8'd60;
  localparam logic [CODE_W-1:0] RST_CODE_FIRST     = 8'd9;
  localparam logic [CODE_W-1:0] RST_CODE_SECOND    = 8'd119;
  localparam logic [CODE_W-1:0] RST_CODE_THIRD     = 8'd127;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SYNC_THRESHOLD = 3'd0,
    CFG_ONE_THRESHOLD  = 3'd1,
    CFG_CODE_FIRST     = 3'd2,
    CFG_CODE_SECOND    = 3'd3,
    CFG_CODE_THIRD     = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_SYNC = 2'd1,
    PH_DATA = 2'd2
  } phase_t;

  typedef struct packed {
    logic [THR_W-1:0]  sync_threshold;
    logic [THR_W-1:0]  one_threshold;
    logic [CODE_W-1:0] code_first;
    logic [CODE_W-1:0] code_second;
    logic [CODE_W-1:0] code_third;
  } cfg_t;

  typedef struct packed {
    logic               frame_done;
    logic [SHIFT_W-1:0] frame_value;
    logic               load_first;
    logic               load_second;
    logic               load_third;
    logic               activity_led;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/pdfr_cfg_regs.sv =====
`default_nettype none
module pdfr_cfg_regs (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_wr_en,
  input  wire logic [pdfr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [pdfr_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output pdfr_pkg::cfg_t                        cfg
);
  import pdfr_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SYNC_THRESHOLD: cfg_nxt.sync_threshold = cfg_wdata[THR_W-1:0];
        CFG_ONE_THRESHOLD:  cfg_nxt.one_threshold  = cfg_wdata[THR_W-1:0];
        CFG_CODE_FIRST:     cfg_nxt.code_first     = cfg_wdata[CODE_W-1:0];
        CFG_CODE_SECOND:    cfg_nxt.code_second    = cfg_wdata[CODE_W-1:0];
        CFG_CODE_THIRD:     cfg_nxt.code_third     = cfg_wdata[CODE_W-1:0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_threshold <= RST_SYNC_THRESHOLD;
      cfg_r.one_threshold  <= RST_ONE_THRESHOLD;
      cfg_r.code_first     <= RST_CODE_FIRST;
      cfg_r.code_second    <= RST_CODE_SECOND;
      cfg_r.code_third     <= RST_CODE_THIRD;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

// ===== rtl/pdfr_core.sv =====
`default_nettype none
module pdfr_core #(
  parameter int BITS_PER_FRAME = pdfr_pkg::DEF_BITS_PER_FRAME,
  parameter int COUNTER_WIDTH  = pdfr_pkg::DEF_COUNTER_WIDTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        fire,
  input  wire logic        line_level,
  input  wire pdfr_pkg::cfg_t cfg,
  output pdfr_pkg::result_t result
);
  import pdfr_pkg::*;

  localparam int CMP_W = (COUNTER_WIDTH > THR_W) ? COUNTER_WIDTH : THR_W;

  logic [COUNTER_WIDTH-1:0] tick_r, tick_nxt;
  logic                     prev_level_r;
  phase_t                   phase_r, phase_nxt;
  logic [BITS_W-1:0]        bits_r, bits_nxt;
  logic [SHIFT_W-1:0]       shift_r, shift_nxt;
  logic [LOADS-1:0]         load_r, load_nxt;

  logic [CMP_W-1:0]  gap;
  logic              falling;
  logic              sync_hit;
  logic              one_bit;
  logic [BITS_W-1:0] bits_dec;
  logic              start;
  logic              shift_en;
  logic              done;
  logic              cleared;
  logic [SHIFT_W-1:0] value;

  // edge and gap decode
  always_comb begin
    gap      = CMP_W'(tick_r);
    falling  = prev_level_r & ~line_level;
    sync_hit = gap >= CMP_W'(cfg.sync_threshold);
    one_bit  = gap >= CMP_W'(cfg.one_threshold);
    bits_dec = bits_r - BITS_W'(1);
    start    = 1'b0;
    shift_en = 1'b0;
    done     = 1'b0;
    cleared  = 1'b0;
    case (phase_r)
      PH_SYNC: begin
        cleared = falling;
        start   = falling & sync_hit;
      end
      PH_DATA: begin
        cleared  = falling;
        shift_en = falling & ~sync_hit;
        done     = falling & (sync_hit | (bits_dec == '0));
      end
      default: begin
        cleared = 1'b0;
      end
    endcase
  end

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      PH_SYNC: if (start) phase_nxt = PH_DATA;
      PH_DATA: if (done) phase_nxt = PH_IDLE;
      default: phase_nxt = line_level ? PH_SYNC : PH_IDLE;
    endcase
  end

  // datapath and result
  always_comb begin
    tick_nxt  = cleared ? '0 : tick_r + COUNTER_WIDTH'(1);
    bits_nxt  = bits_r;
    shift_nxt = shift_r;
    if (start) begin
      bits_nxt  = BITS_W'(BITS_PER_FRAME);
      shift_nxt = '0;
    end else if (shift_en) begin
      bits_nxt  = bits_dec;
      shift_nxt = (shift_r | SHIFT_W'(one_bit)) << 1;
    end
    value    = done ? (shift_nxt >> 1) : '0;
    load_nxt = load_r;
    if (done) begin
      load_nxt[0] = load_r[0] ^ (value == cfg.code_first);
      load_nxt[1] = load_r[1] ^ (value == cfg.code_second);
      load_nxt[2] = load_r[2] ^ (value == cfg.code_third);
    end
    result.frame_done   = done;
    result.frame_value  = value;
    result.load_first   = load_nxt[0];
    result.load_second  = load_nxt[1];
    result.load_third   = load_nxt[2];
    result.activity_led = (phase_nxt != PH_IDLE) & line_level;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r       <= '0;
      prev_level_r <= 1'b0;
      phase_r      <= PH_IDLE;
      bits_r       <= '0;
      shift_r      <= '0;
      load_r       <= '0;
    end else if (fire) begin
      tick_r       <= tick_nxt;
      prev_level_r <= line_level;
      phase_r      <= phase_nxt;
      bits_r       <= bits_nxt;
      shift_r      <= shift_nxt;
      load_r       <= load_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/pdfr_out_reg.sv =====
`default_nettype none
module pdfr_out_reg (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire pdfr_pkg::result_t in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output pdfr_pkg::result_t  out_data
);
  import pdfr_pkg::*;

  logic    valid_r;
  result_t data_r;

  assign in_ready = ~valid_r | out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= in_data;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule
`default_nettype wire

// ===== rtl/pulse_distance_frame_receiver.sv =====
`default_nettype none
// Pulse-distance frame receiver: one line sample is taken per beat on the input
// channel and exactly one result beat comes back for it, held in a single
// output register. A new sample is accepted every cycle while the result side
// takes its beats; the rate of one sample per cycle is set by the single state
// update (tick counter, phase, bit count and shift register) done between the
// sampled state and the output register. Configuration writes take effect on the
// next cycle and should be made while no sample is in flight.
module pulse_distance_frame_receiver #(
  parameter int BITS_PER_FRAME = pdfr_pkg::DEF_BITS_PER_FRAME,
  parameter int COUNTER_WIDTH  = pdfr_pkg::DEF_COUNTER_WIDTH
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic                             in_line_level,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic                                  out_frame_done,
  output logic [pdfr_pkg::SHIFT_W-1:0]          out_frame_value,
  output logic                                  out_load_first,
  output logic                                  out_load_second,
  output logic                                  out_load_third,
  output logic                                  out_activity_led,
  input  wire logic                             cfg_wr_en,
  input  wire logic [pdfr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [pdfr_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import pdfr_pkg::*;

  cfg_t    cfg;
  result_t core_res;
  result_t out_res;
  logic    fire;

  assign fire = in_valid & in_ready;

  pdfr_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  pdfr_core #(
    .BITS_PER_FRAME (BITS_PER_FRAME),
    .COUNTER_WIDTH  (COUNTER_WIDTH)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .line_level (in_line_level),
    .cfg        (cfg),
    .result     (core_res)
  );

  pdfr_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (core_res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_res)
  );

  assign out_frame_done   = out_res.frame_done;
  assign out_frame_value  = out_res.frame_value;
  assign out_load_first   = out_res.load_first;
  assign out_load_second  = out_res.load_second;
  assign out_load_third   = out_res.load_third;
  assign out_activity_led = out_res.activity_led;

endmodule
`default_nettype wire

// ===== verif/tb_pulse_distance_frame_receiver.sv =====
`timescale 1ns / 1ps
module tb_pulse_distance_frame_receiver;
  import pdfr_pkg::*;

  localparam int CLK_HALF      = 6;
  localparam int RESET_CYCLES  = 4;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int MAX_REPORTS   = 10;
  localparam int SETTLE_CYCLES = 4;
  localparam int HOLD_CYCLES   = 40;
  localparam int FRAME_BITS    = DEF_BITS_PER_FRAME;
  localparam int TICK_MAX      = (1 << DEF_COUNTER_WIDTH) - 1;
  localparam int GAP_SPREAD    = 8;
  localparam int NO_ABORT      = FRAME_BITS;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LAST  = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_line_level = 1'b0;
  logic out_ready = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_ready;
  logic out_valid;
  logic out_frame_done;
  logic [SHIFT_W-1:0] out_frame_value;
  logic out_load_first;
  logic out_load_second;
  logic out_load_third;
  logic out_activity_led;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left = 0;
  int cycle_cnt = 0;
  int error_count = 0;
  int beat_count = 0;
  int ticks_sent = 0;

  // receiver model
  cfg_t rx_cfg;
  logic [DEF_COUNTER_WIDTH-1:0] tick_cnt;
  logic prev_level;
  phase_t rx_phase;
  logic [BITS_W-1:0] bits_left;
  logic [SHIFT_W-1:0] shift_reg;
  logic [LOADS-1:0] load_state;
  result_t expected_results[$];

  pulse_distance_frame_receiver i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_line_level    (in_line_level),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_frame_done   (out_frame_done),
    .out_frame_value  (out_frame_value),
    .out_load_first   (out_load_first),
    .out_load_second  (out_load_second),
    .out_load_third   (out_load_third),
    .out_activity_led (out_activity_led),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always #CLK_HALF clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic reset_model();
    rx_cfg.sync_threshold = RST_SYNC_THRESHOLD;
    rx_cfg.one_threshold  = RST_ONE_THRESHOLD;
    rx_cfg.code_first     = RST_CODE_FIRST;
    rx_cfg.code_second    = RST_CODE_SECOND;
    rx_cfg.code_third     = RST_CODE_THIRD;
    tick_cnt   = '0;
    prev_level = 1'b0;
    rx_phase   = PH_IDLE;
    bits_left  = '0;
    shift_reg  = '0;
    load_state = '0;
  endtask

  task automatic predict_tick(input logic level);
    logic falling;
    logic done;
    logic cleared;
    logic bit_val;
    logic [SHIFT_W-1:0] value;
    logic [DEF_COUNTER_WIDTH-1:0] gap;
    result_t r;
    falling = prev_level && !level;
    done    = 1'b0;
    cleared = 1'b0;
    value   = '0;
    gap     = tick_cnt;
    case (rx_phase)
      PH_SYNC: begin
        if (falling) begin
          cleared = 1'b1;
          if (gap >= rx_cfg.sync_threshold) begin
            rx_phase  = PH_DATA;
            bits_left = BITS_W'(FRAME_BITS);
            shift_reg = '0;
          end
        end
      end
      PH_DATA: begin
        if (falling) begin
          cleared = 1'b1;
          if (gap >= rx_cfg.sync_threshold) begin
            done = 1'b1;
          end else begin
            bit_val   = (gap >= rx_cfg.one_threshold);
            shift_reg = (shift_reg | SHIFT_W'(bit_val)) << 1;
            bits_left = bits_left - 1'b1;
            if (bits_left == '0) done = 1'b1;
          end
        end
      end
      default: begin
        rx_phase = level ? PH_SYNC : PH_IDLE;
      end
    endcase
    if (done) begin
      value    = shift_reg >> 1;
      rx_phase = PH_IDLE;
      if (value == rx_cfg.code_first)  load_state[0] = ~load_state[0];
      if (value == rx_cfg.code_second) load_state[1] = ~load_state[1];
      if (value == rx_cfg.code_third)  load_state[2] = ~load_state[2];
    end
    tick_cnt   = cleared ? '0 : tick_cnt + 1'b1;
    prev_level = level;
    r.frame_done   = done;
    r.frame_value  = value;
    r.load_first   = load_state[0];
    r.load_second  = load_state[1];
    r.load_third   = load_state[2];
    r.activity_led = (rx_phase != PH_IDLE) && level;
    expected_results.push_back(r);
  endtask

  task automatic check_field(input string name, input logic [SHIFT_W-1:0] got,
                             input logic [SHIFT_W-1:0] want);
    if (got !== want) begin
      error_count++;
      if (error_count <= MAX_REPORTS)
        $display("beat %0d: %s expected %0h, got %0h", beat_count, name, want, got);
    end
  endtask

  task automatic check_beat();
    result_t want;
    if (expected_results.size() == 0) begin
      error_count++;
      if (error_count <= MAX_REPORTS)
        $display("beat %0d: result with nothing expected", beat_count);
    end else begin
      want = expected_results.pop_front();
      check_field("frame_done", SHIFT_W'(out_frame_done), SHIFT_W'(want.frame_done));
      check_field("frame_value", out_frame_value, want.frame_value);
      check_field("load_first", SHIFT_W'(out_load_first), SHIFT_W'(want.load_first));
      check_field("load_second", SHIFT_W'(out_load_second), SHIFT_W'(want.load_second));
      check_field("load_third", SHIFT_W'(out_load_third), SHIFT_W'(want.load_third));
      check_field("activity_led", SHIFT_W'(out_activity_led),
                  SHIFT_W'(want.activity_led));
    end
    beat_count++;
  endtask

  // result side: checks beats, stalls at random or for a counted hold-off
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_beat();
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic send_level(input logic level);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_line_level <= level;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_tick(level);
    ticks_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DATA_W'(data);
    @(posedge clk);
    case (idx)
      CFG_SYNC_THRESHOLD: rx_cfg.sync_threshold = THR_W'(data);
      CFG_ONE_THRESHOLD:  rx_cfg.one_threshold  = THR_W'(data);
      CFG_CODE_FIRST:     rx_cfg.code_first     = CODE_W'(data);
      CFG_CODE_SECOND:    rx_cfg.code_second    = CODE_W'(data);
      CFG_CODE_THIRD:     rx_cfg.code_third     = CODE_W'(data);
      default: ;
    endcase
  endtask

  task automatic set_config(input int sync_th, input int one_th, input int code_a,
                            input int code_b, input int code_c, input bit spare_write);
    drain();
    write_reg(CFG_SYNC_THRESHOLD, sync_th);
    write_reg(CFG_ONE_THRESHOLD, one_th);
    write_reg(CFG_CODE_FIRST, code_a);
    write_reg(CFG_CODE_SECOND, code_b);
    write_reg(CFG_CODE_THIRD, code_c);
    if (spare_write)
      write_reg(CFG_SPARE_FIRST + $urandom_range(0, CFG_SPARE_LAST - CFG_SPARE_FIRST),
                $urandom_range(0, TICK_MAX));
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // next falling edge lands on a gap in [lo, hi], counted from the current tick count
  task automatic fall_after(input int lo, input int hi);
    int cnt;
    int target;
    int top;
    int span;
    int nlow;
    cnt = tick_cnt;
    if (prev_level && cnt >= lo && cnt <= hi) begin
      send_level(1'b0);
    end else begin
      top = (hi < lo + GAP_SPREAD) ? hi : lo + GAP_SPREAD;
      case ($urandom_range(0, 7))
        0: target = hi;
        1: target = lo;
        default: target = $urandom_range(lo, top);
      endcase
      span = (target - cnt + TICK_MAX + 1) % (TICK_MAX + 1);
      if (span == 0) span = TICK_MAX + 1;
      nlow = prev_level ? 0 : $urandom_range(0, span - 1);
      repeat (nlow) send_level(1'b0);
      repeat (span - nlow) send_level(1'b1);
      send_level(1'b0);
    end
  endtask

  function automatic int abort_top();
    int sync_th;
    sync_th = rx_cfg.sync_threshold;
    return (sync_th + GAP_SPREAD > TICK_MAX) ? TICK_MAX : sync_th + GAP_SPREAD;
  endfunction

  task automatic recover_idle();
    while (rx_phase != PH_IDLE) fall_after(rx_cfg.sync_threshold, abort_top());
  endtask

  task automatic send_frame(input logic [SHIFT_W-1:0] value, input int abort_at);
    int sync_th;
    int one_lo;
    int zero_hi;
    int bit_idx;
    bit ok_one;
    bit ok_zero;
    logic b;
    sync_th = rx_cfg.sync_threshold;
    one_lo  = (rx_cfg.one_threshold > 1) ? rx_cfg.one_threshold : 1;
    zero_hi = ((rx_cfg.one_threshold < sync_th) ? rx_cfg.one_threshold : sync_th) - 1;
    ok_one  = (one_lo <= sync_th - 1);
    ok_zero = (zero_hi >= 1);
    recover_idle();
    repeat ($urandom_range(0, 3)) send_level(1'b0);
    send_level(1'b1);
    fall_after(sync_th, abort_top());
    bit_idx = 0;
    while (rx_phase == PH_DATA) begin
      // the first bit is shifted out of the frame value, so it is free
      b = (bit_idx == 0) ? 1'($urandom_range(0, 1)) : value[FRAME_BITS - 1 - bit_idx];
      if (bit_idx == abort_at || !(ok_one || ok_zero)) begin
        fall_after(sync_th, abort_top());
      end else begin
        if (b && !ok_one) b = 1'b0;
        else if (!b && !ok_zero) b = 1'b1;
        if (b) fall_after(one_lo, sync_th - 1);
        else fall_after(1, zero_hi);
      end
      bit_idx++;
    end
  endtask

  function automatic logic [SHIFT_W-1:0] pick_value();
    case ($urandom_range(0, 5))
      0: return rx_cfg.code_first;
      1: return rx_cfg.code_second;
      2: return rx_cfg.code_third;
      default: return SHIFT_W'($urandom_range(0, 127));
    endcase
  endfunction

  task automatic run_random(input int n_ticks);
    int start;
    int pick;
    start = ticks_sent;
    while (ticks_sent - start < n_ticks) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        send_frame(pick_value(), NO_ABORT);
      end else if (pick < 80) begin
        send_frame(pick_value(), $urandom_range(0, FRAME_BITS - 1));
      end else if (pick < 90) begin
        // sync gap that falls short, then line noise
        recover_idle();
        send_level(1'b1);
        if (rx_cfg.sync_threshold > 1) fall_after(1, rx_cfg.sync_threshold - 1);
        repeat ($urandom_range(2, 8)) send_level(1'($urandom_range(0, 1)));
      end else begin
        repeat ($urandom_range(4, 20)) send_level(1'($urandom_range(0, 1)));
      end
    end
  endtask

  task automatic test_idle_line();
    repeat (6) send_level(1'b0);
    send_level(1'b1);
    send_level(1'b1);
    send_level(1'b0);
    send_level(1'b1);
    send_level(1'b0);
    send_level(1'b0);
  endtask

  task automatic test_equal_codes();
    int code;
    code = $urandom_range(1, 127);
    set_config(3, 2, code, code, code, 1'b1);
    send_frame(SHIFT_W'(code), NO_ABORT);
  endtask

  task automatic test_abort();
    send_frame(SHIFT_W'($urandom_range(0, 127)), 2);
  endtask

  task automatic test_backpressure();
    int saved_pct;
    saved_pct = send_idle_pct;
    send_idle_pct = 0;
    hold_left <= HOLD_CYCLES;
    repeat (30) send_level(1'($urandom_range(0, 1)));
    send_idle_pct = saved_pct;
  endtask

  task automatic test_sender_pause();
    send_frame(pick_value(), NO_ABORT);
    drain();
    send_frame(pick_value(), NO_ABORT);
  endtask

  initial begin
    int code;
    reset_model();
    send_idle_pct = 34;
    recv_idle_pct = 77;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_line();
    test_equal_codes();
    test_abort();

    set_config(6, 3, 9, 119, 127, 1'b0);
    run_random(100);
    test_backpressure();
    set_config(1, 0, 0, 255, $urandom_range(0, 127), 1'b1);
    run_random(40);

    send_idle_pct = 77;
    recv_idle_pct = 34;
    // one long frame at the widest gaps is several hundred beats by itself
    set_config(255, 255, $urandom_range(0, 127), $urandom_range(0, 127), 0, 1'b0);
    run_random(1);
    set_config(9, 0, 127, 127, 0, 1'b0);
    run_random(60);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    code = $urandom_range(0, 127);
    set_config(8, 4, code, code, $urandom_range(0, 127), 1'b1);
    run_random(100);
    test_sender_pause();

    drain();
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
